// ===== sv/ptk_pkg.sv =====
// shared constants and types of the position keeping table
package ptk_pkg;

   localparam int POSITIONS = 64;
   localparam int IDX_W     = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
   localparam int INSTR_W   = 6;

   localparam logic [1:0] CMD_TRADE = 2'd0;
   localparam logic [1:0] CMD_LAST  = 2'd1;
   localparam logic [1:0] CMD_QUOTE = 2'd2;

   typedef struct packed {
      logic [7:0]         symbol;
      logic signed [31:0] qty;
      logic [31:0]        avg;
      logic [31:0]        market;
      logic signed [63:0] realized;
      logic signed [63:0] unrealized;
      logic [63:0]        stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic signed [31:0] qty;
      logic [31:0]        avg;
      logic signed [63:0] realized;
      logic signed [63:0] unrealized;
      logic [63:0]        stamp;
      logic               sat;
   } res_type;

endpackage

// ===== sv/ptk_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module ptk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ptk_div.sv =====
// restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle
module ptk_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 32'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[31:0];

endmodule

// ===== sv/position_keeping_table_core.sv =====
// position keeping table: average-cost positions in a ram, trade and reprice sequencer
//
// one item is worked at a time; req_ready is high only while the sequencer is idle.
// a trade reads its entry and runs its products on the shared 34x34 multiplier. on
// an add or open from flat it also runs a 64-step restoring divide for the new
// average. req_ready comes back in the cycle after the final result transfer.
// a last price or quote walks every table entry through the ram read port. an
// entry that does not match passes through read, check and next; one that
// matches passes through read, check, multiply, apply and next, plus the result
// wait for each result that goes out. results of a scan come out by ascending
// entry; the final one carries rsp_last. a last price or quote at or below
// price_floor, an unknown command or an instrument outside the table gives no
// result. csr writes are always taken.
module position_keeping_table_core
   import ptk_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_price_floor,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [5:0]         req_instrument,
   input  logic [7:0]         req_symbol_id,
   input  logic               req_sell_side,
   input  logic [30:0]        req_trade_qty,
   input  logic [31:0]        req_price,
   input  logic [31:0]        req_ask_price,
   input  logic [63:0]        req_stamp,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_entry,
   output logic signed [31:0] rsp_net_qty,
   output logic [31:0]        rsp_avg_cost,
   output logic signed [63:0] rsp_realized,
   output logic signed [63:0] rsp_unrealized,
   output logic [63:0]        rsp_updated_at,
   output logic               rsp_saturated,
   output logic               rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_T_LOAD, ST_T_MUL_A, ST_T_MUL_B, ST_T_PROD, ST_T_DIV_GO, ST_T_DIV,
      ST_T_UNR_A, ST_T_UNR_B, ST_T_UNR_C, ST_S_READ, ST_S_CHECK, ST_S_MUL,
      ST_S_APPLY, ST_S_WAIT, ST_S_NEXT
   } state_type;

   typedef enum logic [1:0] {K_CLOSE, K_ADD, K_REDUCE, K_FLIP} kind_type;

   localparam logic signed [33:0] QTY_MAX = 34'sd2147483647;
   localparam logic signed [33:0] QTY_MIN = -34'sd2147483648;

   // control state
   state_type            state_ff, state_in;
   logic [POSITIONS-1:0] valid_ff, valid_in;
   logic [31:0]          floor_ff, floor_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 have_ff, have_in;

   // item and working payload
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [7:0]           sym_ff, sym_in;
   logic                 sell_ff, sell_in;
   logic [30:0]          tqty_ff, tqty_in;
   logic [31:0]          price_ff, price_in;
   logic [63:0]          stamp_ff, stamp_in;
   entry_type            ent_ff, ent_in;
   logic signed [31:0]   oldq_ff, oldq_in;
   logic [31:0]          absold_ff, absold_in;
   logic [32:0]          abseff_ff, abseff_in;
   logic [31:0]          absnew_ff, absnew_in;
   kind_type             kind_ff, kind_in;
   logic                 sat_ff, sat_in;
   logic signed [33:0]   mul_a_ff, mul_a_in;
   logic signed [33:0]   mul_b_ff, mul_b_in;
   logic signed [67:0]   prod_ff;
   logic [63:0]          part_ff, part_in;
   res_type              hold_ff, hold_in;
   res_type              rsp_ff, rsp_in;
   logic                 rsp_last_ff, rsp_last_in;

   // ram and divider hookup
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [IDX_W-1:0]     ram_raddr;
   entry_type            ram_wdata;
   entry_type            ram_rdata;
   logic                 div_start;
   logic [63:0]          div_num;
   logic                 div_done;
   logic [31:0]          div_quo;

   // scratch for the combinational step
   entry_type            e;
   entry_type            upd;
   logic signed [33:0]   sum;
   logic signed [33:0]   newq;
   logic signed [33:0]   eff;
   logic signed [33:0]   oldq_x;
   logic signed [33:0]   absn;
   logic signed [33:0]   abse;
   logic signed [33:0]   abso;
   logic signed [63:0]   prod64;
   logic signed [63:0]   delta;
   logic signed [64:0]   rsum;
   logic [32:0]          mid;
   logic [31:0]          px;
   logic                 same_sign;

   ptk_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(POSITIONS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   ptk_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_num),
      .divisor (absnew_ff),
      .done    (div_done),
      .quotient(div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      floor_in     = floor_ff;
      rsp_valid_in = rsp_valid_ff;
      have_in      = have_ff;
      idx_in       = idx_ff;
      scan_in      = scan_ff;
      sym_in       = sym_ff;
      sell_in      = sell_ff;
      tqty_in      = tqty_ff;
      price_in     = price_ff;
      stamp_in     = stamp_ff;
      ent_in       = ent_ff;
      oldq_in      = oldq_ff;
      absold_in    = absold_ff;
      abseff_in    = abseff_ff;
      absnew_in    = absnew_ff;
      kind_in      = kind_ff;
      sat_in       = sat_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      part_in      = part_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_last_in  = rsp_last_ff;

      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_raddr    = (state_ff == ST_IDLE) ? req_instrument[IDX_W-1:0] : scan_ff;
      div_start    = 1'b0;
      div_num      = part_ff + prod_ff[63:0];

      upd          = ent_ff;
      prod64       = prod_ff[63:0];
      delta        = oldq_ff[31] ? -prod64 : prod64;
      rsum         = {ent_ff.realized[63], ent_ff.realized} + {delta[63], delta};
      mid          = ({1'b0, req_price} + {1'b0, req_ask_price}) >> 1;
      px           = (req_command == CMD_QUOTE) ? mid[31:0] : req_price;

      // trade arithmetic on the entry just read
      e            = ram_rdata;
      if (!valid_ff[idx_ff]) begin
         e            = '0;
         e.symbol     = sym_ff;
      end
      oldq_x       = {{2{e.qty[31]}}, e.qty};
      sum          = sell_ff ? oldq_x - $signed({3'b0, tqty_ff})
                             : oldq_x + $signed({3'b0, tqty_ff});
      newq         = sum;
      if (sum > QTY_MAX) begin
         newq = QTY_MAX;
      end else if (sum < QTY_MIN) begin
         newq = QTY_MIN;
      end
      eff          = newq - oldq_x;
      abso         = oldq_x[33] ? -oldq_x : oldq_x;
      abse         = eff[33] ? -eff : eff;
      absn         = newq[33] ? -newq : newq;
      same_sign    = (oldq_x > 0) == (newq > 0);

      if (csr_valid) begin
         floor_in = csr_price_floor;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in   = req_instrument[IDX_W-1:0];
               sym_in   = req_symbol_id;
               sell_in  = req_sell_side;
               tqty_in  = req_trade_qty;
               stamp_in = req_stamp;
               price_in = px;
               scan_in  = '0;
               have_in  = 1'b0;
               if (req_command == CMD_TRADE) begin
                  if ({1'b0, req_instrument} < (INSTR_W+1)'(POSITIONS)) begin
                     state_in = ST_T_LOAD;
                  end
               end else if (req_command == CMD_LAST || req_command == CMD_QUOTE) begin
                  // the scan starts with a read of entry zero
                  if (px > floor_ff) begin
                     state_in = ST_S_READ;
                  end
               end
            end
         end
         ST_T_LOAD: begin
            ent_in     = e;
            ent_in.qty = newq[31:0];
            oldq_in    = e.qty;
            absold_in  = abso[31:0];
            abseff_in  = abse[32:0];
            absnew_in  = absn[31:0];
            sat_in     = (sum != newq);
            if (newq == 0) begin
               kind_in = K_CLOSE;
            end else if (oldq_x == 0 || (same_sign && absn >= abso)) begin
               kind_in = K_ADD;
            end else if (same_sign) begin
               kind_in = K_REDUCE;
            end else begin
               kind_in = K_FLIP;
            end
            state_in = ST_T_MUL_A;
         end
         ST_T_MUL_A: begin
            // first product: old cost weight, or price move on the closed part
            if (kind_ff == K_ADD) begin
               mul_a_in = $signed({2'b0, ent_ff.avg});
               mul_b_in = $signed({2'b0, absold_ff});
            end else begin
               mul_a_in = $signed({2'b0, price_ff}) - $signed({2'b0, ent_ff.avg});
               mul_b_in = (kind_ff == K_REDUCE) ? $signed({1'b0, abseff_ff})
                                                : $signed({2'b0, absold_ff});
            end
            state_in = ST_T_MUL_B;
         end
         ST_T_MUL_B: begin
            mul_a_in = $signed({2'b0, price_ff});
            mul_b_in = $signed({1'b0, abseff_ff});
            state_in = ST_T_PROD;
         end
         ST_T_PROD: begin
            if (kind_ff == K_ADD) begin
               part_in  = prod64;
               state_in = ST_T_DIV_GO;
            end else begin
               // realized profit with clamp at the signed 64-bit limits
               if (rsum[64] != rsum[63]) begin
                  sat_in          = 1'b1;
                  ent_in.realized = rsum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
               end else begin
                  ent_in.realized = rsum[63:0];
               end
               if (kind_ff == K_CLOSE) begin
                  ent_in.avg = '0;
               end else if (kind_ff == K_FLIP) begin
                  ent_in.avg = price_ff;
               end
               state_in = ST_T_UNR_A;
            end
         end
         ST_T_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_T_DIV;
         end
         ST_T_DIV: begin
            if (div_done) begin
               ent_in.avg = div_quo;
               state_in   = ST_T_UNR_A;
            end
         end
         ST_T_UNR_A: begin
            mul_a_in = $signed({{2{ent_ff.qty[31]}}, ent_ff.qty});
            mul_b_in = $signed({2'b0, ent_ff.market}) - $signed({2'b0, ent_ff.avg});
            state_in = ST_T_UNR_B;
         end
         ST_T_UNR_B: begin
            state_in = ST_T_UNR_C;
         end
         ST_T_UNR_C: begin
            upd.stamp = stamp_ff;
            if (ent_ff.qty != 0 && ent_ff.market > floor_ff) begin
               upd.unrealized = prod64;
            end
            ram_we           = 1'b1;
            valid_in[idx_ff] = 1'b1;
            rsp_in           = '{idx: idx_ff, qty: upd.qty, avg: upd.avg,
                                 realized: upd.realized, unrealized: upd.unrealized,
                                 stamp: upd.stamp, sat: sat_ff};
            rsp_last_in      = 1'b1;
            rsp_valid_in     = 1'b1;
            state_in         = ST_S_WAIT;
         end
         ST_S_READ: begin
            state_in = ST_S_CHECK;
         end
         ST_S_CHECK: begin
            if (valid_ff[scan_ff] && ram_rdata.symbol == sym_ff) begin
               ent_in        = ram_rdata;
               ent_in.market = price_ff;
               mul_a_in      = $signed({{2{ram_rdata.qty[31]}}, ram_rdata.qty});
               mul_b_in      = $signed({2'b0, price_ff}) - $signed({2'b0, ram_rdata.avg});
               state_in      = ST_S_MUL;
            end else begin
               state_in = ST_S_NEXT;
            end
         end
         ST_S_MUL: begin
            state_in = ST_S_APPLY;
         end
         ST_S_APPLY: begin
            if (ent_ff.qty != 0) begin
               upd.unrealized = prod64;
            end
            ram_we    = 1'b1;
            ram_waddr = scan_ff;
            hold_in   = '{idx: scan_ff, qty: upd.qty, avg: upd.avg,
                          realized: upd.realized, unrealized: upd.unrealized,
                          stamp: upd.stamp, sat: 1'b0};
            have_in   = 1'b1;
            // a held match goes out now, knowing another one follows it
            if (have_ff) begin
               rsp_in       = hold_ff;
               rsp_last_in  = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_S_WAIT;
            end else begin
               state_in = ST_S_NEXT;
            end
         end
         ST_S_WAIT: begin
            // result transfer; the trade path and the end of a scan finish here
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = rsp_last_ff ? ST_IDLE : ST_S_NEXT;
            end
         end
         ST_S_NEXT: begin
            if (scan_ff == IDX_W'(POSITIONS - 1)) begin
               if (have_ff) begin
                  rsp_in       = hold_ff;
                  rsp_last_in  = 1'b1;
                  rsp_valid_in = 1'b1;
                  have_in      = 1'b0;
                  state_in     = ST_S_WAIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               scan_in  = scan_ff + IDX_W'(1);
               state_in = ST_S_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ram_wdata = upd;
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      scan_ff     <= scan_in;
      sym_ff      <= sym_in;
      sell_ff     <= sell_in;
      tqty_ff     <= tqty_in;
      price_ff    <= price_in;
      stamp_ff    <= stamp_in;
      ent_ff      <= ent_in;
      oldq_ff     <= oldq_in;
      absold_ff   <= absold_in;
      abseff_ff   <= abseff_in;
      absnew_ff   <= absnew_in;
      kind_ff     <= kind_in;
      sat_ff      <= sat_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      prod_ff     <= mul_a_ff * mul_b_ff;
      part_ff     <= part_in;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         floor_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         floor_ff     <= floor_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ff      <= have_in;
      end
   end

   assign csr_ready      = 1'b1;
   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_entry      = INSTR_W'(rsp_ff.idx);
   assign rsp_net_qty    = rsp_ff.qty;
   assign rsp_avg_cost   = rsp_ff.avg;
   assign rsp_realized   = rsp_ff.realized;
   assign rsp_unrealized = rsp_ff.unrealized;
   assign rsp_updated_at = rsp_ff.stamp;
   assign rsp_saturated  = rsp_ff.sat;
   assign rsp_last       = rsp_last_ff;

endmodule
